// ===== hdl/spinor_pkg.sv =====
// Package for the SPI NOR flash command sequencer.
// Holds codes, flash command bytes, the queue descriptor type and the step table.
// No dependencies.
`default_nettype none

package spinor_pkg;

  localparam int ADDR_BYTES = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic [1:0] KIND_HOST = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_RECV = 2'd2;

  localparam logic [2:0] OP_RDID   = 3'd0;
  localparam logic [2:0] OP_WREN   = 3'd1;
  localparam logic [2:0] OP_WRDIS  = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_PROG   = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_INIT   = 3'd6;

  localparam logic [7:0] CMD_RDID  = 8'h90;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_WRDIS = 8'h04;
  localparam logic [7:0] CMD_RDSR1 = 8'h05;
  localparam logic [7:0] CMD_RDSR2 = 8'h35;
  localparam logic [7:0] CMD_WRSR  = 8'h01;
  localparam logic [7:0] CMD_SE    = 8'h20;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h03;

  // first init round clears SR1 bit 7 and SR2 bit 0, second clears SR1 bits 2..4 and 6
  localparam logic [7:0] SR1_KEEP_R0 = ~(8'h01 << 7);
  localparam logic [7:0] SR2_KEEP_R0 = ~(8'h01 << 0);
  localparam logic [7:0] SR1_KEEP_R1 = ~((8'h07 << 2) | (8'h01 << 6));

  typedef enum logic [2:0] {
    ACT_SEL, ACT_DESEL, ACT_SEND, ACT_RECV, ACT_HOST, ACT_DONE
  } act_t;

  typedef enum logic [3:0] {
    BS_ZERO, BS_ARG, BS_A2, BS_A1, BS_A0, BS_C06, BS_C05, BS_C35, BS_C01, BS_S1, BS_S2
  } src_t;

  typedef enum logic [3:0] {
    Q_WE, Q_READ, Q_RD0, Q_DATA, Q_HOST, Q_HOSTD, Q_SIMPLE, Q_SR2, Q_WRSR
  } seq_t;

  typedef struct packed {
    seq_t        seq;
    logic [3:0]  first;
    logic [3:0]  stop;
    logic [7:0]  arg;
    logic [23:0] addr;
    logic [7:0]  s1;
    logic [7:0]  s2;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_rd_t;

  typedef struct packed {
    act_t act;
    src_t src;
  } step_t;

  function automatic step_t mk(act_t a, src_t s);
    step_t r;
    r.act = a;
    r.src = s;
    return r;
  endfunction

  function automatic step_t seq_step(seq_t seq, logic [3:0] idx);
    step_t r;
    r = mk(ACT_SEL, BS_ZERO);
    case (seq)
      Q_WE: begin
        case (idx)
          4'd0:    r = mk(ACT_SEL, BS_ZERO);
          4'd1:    r = mk(ACT_SEND, BS_C06);
          4'd2:    r = mk(ACT_DESEL, BS_ZERO);
          4'd3:    r = mk(ACT_SEL, BS_ZERO);
          4'd4:    r = mk(ACT_SEND, BS_ARG);
          4'd5:    r = mk(ACT_SEND, BS_A2);
          4'd6:    r = mk(ACT_SEND, BS_A1);
          4'd7:    r = mk(ACT_SEND, BS_A0);
          4'd8:    r = mk(ACT_DESEL, BS_ZERO);
          4'd9:    r = mk(ACT_SEL, BS_ZERO);
          4'd10:   r = mk(ACT_SEND, BS_C05);
          default: r = mk(ACT_RECV, BS_ZERO);
        endcase
      end
      Q_READ, Q_RD0: begin
        case (idx)
          4'd0:    r = mk(ACT_SEL, BS_ZERO);
          4'd1:    r = mk(ACT_SEND, BS_ARG);
          4'd2:    r = mk(ACT_SEND, BS_A2);
          4'd3:    r = mk(ACT_SEND, BS_A1);
          4'd4:    r = mk(ACT_SEND, BS_A0);
          4'd5:    r = (seq == Q_READ) ? mk(ACT_RECV, BS_ZERO) : mk(ACT_DESEL, BS_ZERO);
          default: r = mk(ACT_DONE, BS_ZERO);
        endcase
      end
      Q_DATA: begin
        case (idx)
          4'd0:    r = mk(ACT_SEND, BS_ARG);
          4'd1:    r = mk(ACT_DESEL, BS_ZERO);
          4'd2:    r = mk(ACT_SEL, BS_ZERO);
          4'd3:    r = mk(ACT_SEND, BS_C05);
          default: r = mk(ACT_RECV, BS_ZERO);
        endcase
      end
      Q_HOST: begin
        case (idx)
          4'd0:    r = mk(ACT_HOST, BS_ARG);
          default: r = mk(ACT_RECV, BS_ZERO);
        endcase
      end
      Q_HOSTD: begin
        case (idx)
          4'd0:    r = mk(ACT_HOST, BS_ARG);
          4'd1:    r = mk(ACT_DESEL, BS_ZERO);
          default: r = mk(ACT_DONE, BS_ZERO);
        endcase
      end
      Q_SIMPLE: begin
        case (idx)
          4'd0:    r = mk(ACT_SEL, BS_ZERO);
          4'd1:    r = mk(ACT_SEND, BS_ARG);
          4'd2:    r = mk(ACT_DESEL, BS_ZERO);
          default: r = mk(ACT_DONE, BS_ZERO);
        endcase
      end
      Q_SR2: begin
        case (idx)
          4'd0:    r = mk(ACT_DESEL, BS_ZERO);
          4'd1:    r = mk(ACT_SEL, BS_ZERO);
          4'd2:    r = mk(ACT_SEND, BS_C35);
          default: r = mk(ACT_RECV, BS_ZERO);
        endcase
      end
      Q_WRSR: begin
        case (idx)
          4'd0:    r = mk(ACT_DESEL, BS_ZERO);
          4'd1:    r = mk(ACT_SEL, BS_ZERO);
          4'd2:    r = mk(ACT_SEND, BS_C06);
          4'd3:    r = mk(ACT_DESEL, BS_ZERO);
          4'd4:    r = mk(ACT_SEL, BS_ZERO);
          4'd5:    r = mk(ACT_SEND, BS_C01);
          4'd6:    r = mk(ACT_SEND, BS_S1);
          4'd7:    r = mk(ACT_SEND, BS_S2);
          4'd8:    r = mk(ACT_DESEL, BS_ZERO);
          4'd9:    r = mk(ACT_SEL, BS_ZERO);
          4'd10:   r = mk(ACT_SEND, BS_C05);
          default: r = mk(ACT_RECV, BS_ZERO);
        endcase
      end
      default: r = mk(ACT_SEL, BS_ZERO);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/spi_nor_flash_command_sequencer.sv =====
// Top level of the SPI NOR flash command sequencer.
// Instantiates spinor_front, spinor_queue and spinor_back; uses spinor_pkg.
//
// Input stream: each request carries a kind in in_tuser (host request,
// program data byte, byte received from the flash) and op, address, length
// and data in in_tdata. Output stream: one bus action per item in out_tuser
// (select, deselect, send, receive, host byte, done), its byte in out_tdata,
// and out_tlast on the final action caused by one request.
// A request is accepted in any cycle the 4-entry descriptor queue has room,
// so requests may follow back to back. An accepted request yields 0 to 12
// actions; the back end issues one action per cycle while out_tready does
// not stall it. The request's descriptor is first written into the queue,
// and its actions then leave through the back end's output register. A
// request arriving outside the phase that awaits it produces no actions.
// Reset (synchronous, rst_n low) returns to idle, clears all status and
// empties the queue. When out_tready is low the output register holds; the
// queue keeps taking requests until full, then in_tready drops.
`default_nettype none

module spi_nor_flash_command_sequencer
  import spinor_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,  // op[2:0], flash_addr[26:3], length[42:27], data[50:43]
  input  wire logic [1:0]  in_tuser,  // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // byte_value[7:0]
  output logic [2:0]       out_tuser, // action[2:0]
  output logic             out_tlast
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;
  act_t  act;

  spinor_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_op    (in_tdata[2:0]),
    .in_addr  (in_tdata[26:3]),
    .in_len   (in_tdata[42:27]),
    .in_data  (in_tdata[50:43]),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  spinor_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .pop   (q_pop),
    .rd    (q_rd),
    .full  (q_full)
  );

  spinor_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (q_rd),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_act   (act),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

  assign out_tuser = act;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_full)
    else $error("descriptor pushed into full queue");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (act == ACT_DONE || act == ACT_RECV) |-> out_tlast)
    else $error("done or receive action not last of its request");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (act == ACT_SEL || act == ACT_DESEL || act == ACT_RECV ||
                   act == ACT_DONE) |-> out_tdata == 8'd0)
    else $error("non-data action carries a byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== hdl/spinor_front.sv =====
// Front end: accepts requests, tracks the command phase and status bytes,
// and pushes one action-sequence descriptor per productive request. Uses spinor_pkg.
`default_nettype none

module spinor_front
  import spinor_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_op,
  input  wire logic [23:0] in_addr,
  input  wire logic [15:0] in_len,
  input  wire logic [7:0]  in_data,
  input  wire logic        q_full,
  output q_wr_t            q_wr
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ID_MFR, PH_ID_DEV, PH_PROG_DATA, PH_READ_DATA, PH_POLL,
    PH_INIT_SR1, PH_INIT_SR2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  active_op_r, active_op_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        init_round_r, init_round_nxt;
  logic [7:0]  status_one_r, status_one_nxt;
  logic [7:0]  status_two_r, status_two_nxt;
  logic [15:0] bl_dec;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign bl_dec   = bytes_left_r - 16'd1;

  always_comb begin
    phase_nxt      = phase_r;
    active_op_nxt  = active_op_r;
    bytes_left_nxt = bytes_left_r;
    init_round_nxt = init_round_r;
    status_one_nxt = status_one_r;
    status_two_nxt = status_two_r;
    q_wr.push       = 1'b0;
    q_wr.desc.seq   = Q_DATA;
    q_wr.desc.first = 4'd0;
    q_wr.desc.stop  = 4'd0;
    q_wr.desc.arg   = in_data;
    q_wr.desc.addr  = in_addr;
    q_wr.desc.s1    = status_one_r;
    q_wr.desc.s2    = status_two_r;
    if (accept) begin
      case (in_kind)
        KIND_HOST: begin
          if (phase_r == PH_IDLE) begin
            active_op_nxt = in_op;
            case (in_op)
              OP_RDID: begin
                q_wr.push      = 1'b1;
                q_wr.desc.seq  = Q_READ;
                q_wr.desc.stop = 4'd5;
                q_wr.desc.arg  = CMD_RDID;
                q_wr.desc.addr = 24'd0;
                phase_nxt      = PH_ID_MFR;
              end
              OP_WREN, OP_WRDIS: begin
                q_wr.push      = 1'b1;
                q_wr.desc.seq  = Q_SIMPLE;
                q_wr.desc.stop = 4'd3;
                q_wr.desc.arg  = (in_op == OP_WREN) ? CMD_WREN : CMD_WRDIS;
              end
              OP_ERASE: begin
                q_wr.push      = 1'b1;
                q_wr.desc.seq  = Q_WE;
                q_wr.desc.stop = 4'd11;
                q_wr.desc.arg  = CMD_SE;
                phase_nxt      = PH_POLL;
              end
              OP_PROG: begin
                q_wr.push      = 1'b1;
                q_wr.desc.seq  = Q_WE;
                q_wr.desc.arg  = CMD_PP;
                bytes_left_nxt = in_len;
                if (in_len == 16'd0) begin
                  q_wr.desc.stop = 4'd11;
                  phase_nxt      = PH_POLL;
                end else begin
                  q_wr.desc.stop = 4'd7;
                  phase_nxt      = PH_PROG_DATA;
                end
              end
              OP_READ: begin
                q_wr.push      = 1'b1;
                q_wr.desc.arg  = CMD_READ;
                bytes_left_nxt = in_len;
                if (in_len == 16'd0) begin
                  q_wr.desc.seq  = Q_RD0;
                  q_wr.desc.stop = 4'd6;
                end else begin
                  q_wr.desc.seq  = Q_READ;
                  q_wr.desc.stop = 4'd5;
                  phase_nxt      = PH_READ_DATA;
                end
              end
              OP_INIT: begin
                q_wr.push       = 1'b1;
                q_wr.desc.first = 4'd2;
                q_wr.desc.stop  = 4'd4;
                init_round_nxt  = 1'b0;
                phase_nxt       = PH_INIT_SR1;
              end
              default: ;
            endcase
          end
        end
        KIND_DATA: begin
          if (phase_r == PH_PROG_DATA) begin
            q_wr.push      = 1'b1;
            bytes_left_nxt = bl_dec;
            if (bl_dec == 16'd0) begin
              q_wr.desc.stop = 4'd4;
              phase_nxt      = PH_POLL;
            end
          end
        end
        KIND_RECV: begin
          case (phase_r)
            PH_ID_MFR: begin
              q_wr.push      = 1'b1;
              q_wr.desc.seq  = Q_HOST;
              q_wr.desc.stop = 4'd1;
              phase_nxt      = PH_ID_DEV;
            end
            PH_ID_DEV: begin
              q_wr.push      = 1'b1;
              q_wr.desc.seq  = Q_HOSTD;
              q_wr.desc.stop = 4'd2;
              phase_nxt      = PH_IDLE;
            end
            PH_READ_DATA: begin
              q_wr.push      = 1'b1;
              bytes_left_nxt = bl_dec;
              if (bl_dec != 16'd0) begin
                q_wr.desc.seq  = Q_HOST;
                q_wr.desc.stop = 4'd1;
              end else begin
                q_wr.desc.seq  = Q_HOSTD;
                q_wr.desc.stop = 4'd2;
                phase_nxt      = PH_IDLE;
              end
            end
            PH_INIT_SR1: begin
              q_wr.push      = 1'b1;
              q_wr.desc.seq  = Q_SR2;
              q_wr.desc.stop = 4'd3;
              status_one_nxt = in_data;
              phase_nxt      = PH_INIT_SR2;
            end
            PH_INIT_SR2: begin
              if (!init_round_r) begin
                status_one_nxt = status_one_r & SR1_KEEP_R0;
                status_two_nxt = in_data & SR2_KEEP_R0;
              end else begin
                status_one_nxt = status_one_r & SR1_KEEP_R1;
                status_two_nxt = in_data;
              end
              q_wr.push      = 1'b1;
              q_wr.desc.seq  = Q_WRSR;
              q_wr.desc.stop = 4'd11;
              q_wr.desc.s1   = status_one_nxt;
              q_wr.desc.s2   = status_two_nxt;
              phase_nxt      = PH_POLL;
            end
            PH_POLL: begin
              q_wr.push = 1'b1;
              if (in_data[0]) begin
                q_wr.desc.first = 4'd1;
                q_wr.desc.stop  = 4'd4;
              end else if (active_op_r == OP_INIT && !init_round_r) begin
                q_wr.desc.first = 4'd1;
                q_wr.desc.stop  = 4'd4;
                init_round_nxt  = 1'b1;
                phase_nxt       = PH_INIT_SR1;
              end else begin
                q_wr.desc.seq   = Q_HOSTD;
                q_wr.desc.first = 4'd1;
                q_wr.desc.stop  = 4'd2;
                phase_nxt       = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      active_op_r  <= 3'd0;
      bytes_left_r <= 16'd0;
      init_round_r <= 1'b0;
      status_one_r <= 8'd0;
      status_two_r <= 8'd0;
    end else begin
      phase_r      <= phase_nxt;
      active_op_r  <= active_op_nxt;
      bytes_left_r <= bytes_left_nxt;
      init_round_r <= init_round_nxt;
      status_one_r <= status_one_nxt;
      status_two_r <= status_two_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spinor_queue.sv =====
// Descriptor queue between front and back ends of the sequencer.
// Q_DEPTH entries, first word fall through. Uses spinor_pkg.
`default_nettype none

module spinor_queue
  import spinor_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  q_wr_t      wr,
  input  wire logic  pop,
  output q_rd_t      rd,
  output logic       full
);

  desc_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic               do_pop;

  assign full     = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign rd.valid = (count_r != '0);
  assign rd.desc  = mem_r[rd_ptr_r];
  assign do_pop   = pop && rd.valid;

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem_r[wr_ptr_r] <= wr.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      count_r <= count_r + (Q_PTR_W+1)'(wr.push) - (Q_PTR_W+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spinor_back.sv =====
// Back end: walks the head descriptor one bus action per cycle, unless
// stalled, into the registered output. Uses spinor_pkg step table.
`default_nettype none

module spinor_back
  import spinor_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  q_rd_t      rd,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output act_t       out_act,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       out_valid_r;
  act_t       out_act_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [3:0] off_r;
  logic [3:0] idx;
  step_t      step;
  logic       at_stop;
  logic       advance;
  logic [7:0] byte_val;

  assign idx     = rd.desc.first + off_r;
  assign step    = seq_step(rd.desc.seq, idx);
  assign at_stop = (idx == rd.desc.stop);
  assign advance = rd.valid && (!out_valid_r || out_ready);
  assign pop     = advance && at_stop;

  always_comb begin
    case (step.src)
      BS_ARG:  byte_val = rd.desc.arg;
      BS_A2:   byte_val = rd.desc.addr[23:16];
      BS_A1:   byte_val = rd.desc.addr[15:8];
      BS_A0:   byte_val = rd.desc.addr[7:0];
      BS_C06:  byte_val = CMD_WREN;
      BS_C05:  byte_val = CMD_RDSR1;
      BS_C35:  byte_val = CMD_RDSR2;
      BS_C01:  byte_val = CMD_WRSR;
      BS_S1:   byte_val = rd.desc.s1;
      BS_S2:   byte_val = rd.desc.s2;
      default: byte_val = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      off_r       <= 4'd0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      off_r       <= at_stop ? 4'd0 : off_r + 4'd1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_act_r  <= step.act;
      out_byte_r <= byte_val;
      out_last_r <= at_stop;
    end
  end

  assign out_valid = out_valid_r;
  assign out_act   = out_act_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire
